// ----- hw/rtl/ircc_pkg.sv -----
// Shared types and constants of the installed range coverage check.
`timescale 1ns / 1ps
`default_nettype none

package ircc_pkg;

    localparam int MAX_RANGES = 16;
    localparam int IDX_W      = $clog2(MAX_RANGES);
    localparam int CNT_W      = IDX_W + 1;
    localparam int ADDR_W     = 64;
    localparam int ENTRY_W    = 2 * ADDR_W;

    // Stream payload widths: fields packed from bit 0, padded to whole bytes.
    localparam int IN_FIELDS_W  = IDX_W + 2 * ADDR_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W  = 8;

    // Command codes carried in tuser.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EVAL,
        S_RESULT
    } t_state;

endpackage

`default_nettype wire

// ----- hw/rtl/installed_range_coverage_check_core.sv -----
// Top level: range table, overlap scan and coverage sweep over installed ranges.
//
// Channel   Dir  Handshake                  Payload
// -------   ---  -------------------------  ------------------------------------------
// s_axis    in   i_s_axis_tvalid/o_..tready tuser: command; tdata: entry_index,
//                                           start_address, byte_size
// m_axis    out  o_m_axis_tvalid/i_..tready tdata: any_overlap, fully_covered
//
// A write item stores its entry in the same cycle it is accepted, and its result
// goes through the RESULT state into the output register; a malformed query
// window takes the same path. A query sweeps the table in passes: each pass
// streams the live entries through the two-stage read pipeline (table RAM, then
// base, end and flags) and then decides in the EVAL state; a query needs at
// most (live entries + 1) passes, bounded by the number of distinct entry ends.
// Reset clears a valid bit per entry, so an entry never written reads as zero
// length and ends the list; the RAM itself is not cleared. A stalled output
// holds its result while the next item is still taken and worked on; that
// item's result then waits, and no further item is taken until the first result
// has been handed over.
`timescale 1ns / 1ps
`default_nettype none

module installed_range_coverage_check_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // s_axis: tuser = {command}; tdata = {pad, byte_size, start_address, entry_index}
    input  wire logic                            i_s_axis_tvalid,
    output      logic                            o_s_axis_tready,
    input  wire logic [ircc_pkg::IN_TDATA_W-1:0] i_s_axis_tdata,   // [3:0] entry_index,
                                                                   // [67:4] start_address,
                                                                   // [131:68] byte_size
    input  wire logic [0:0]                      i_s_axis_tuser,   // [0] command
    // m_axis
    output      logic                            o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    output      logic [ircc_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata   // [0] any_overlap,
                                                                   // [1] fully_covered
);

    localparam int AW = ircc_pkg::ADDR_W;
    localparam int IW = ircc_pkg::IDX_W;

    // Input fields.
    logic [IW-1:0] in_idx;
    logic [AW-1:0] in_addr;
    logic [AW-1:0] in_size;
    logic          in_cmd;
    logic [AW:0]   win_sum;

    assign in_idx  = i_s_axis_tdata[IW-1:0];
    assign in_addr = i_s_axis_tdata[IW+AW-1:IW];
    assign in_size = i_s_axis_tdata[IW+2*AW-1:IW+AW];
    assign in_cmd  = i_s_axis_tuser[0];
    assign win_sum = {1'b0, in_addr} + {1'b0, in_size};

    // Control and datapath registers.
    ircc_pkg::t_state r_state, n_state;
    logic [ircc_pkg::MAX_RANGES-1:0] r_valid, n_valid;
    logic [ircc_pkg::CNT_W-1:0]      r_iss, n_iss;
    logic r_p1_v, n_p1_v, r_p1_last, n_p1_last, r_p1_ok, n_p1_ok;
    logic r_p2_v, n_p2_v, r_p2_last, n_p2_last;
    logic r_p2_live, n_p2_live, r_p2_use, n_p2_use;
    logic [AW-1:0] r_p2_base, n_p2_base, r_p2_end, n_p2_end;
    logic [AW-1:0] r_addr, n_addr, r_wend, n_wend;
    logic [AW-1:0] r_cursor, n_cursor, r_best, n_best;
    logic r_any, n_any;
    logic r_res_any, n_res_any, r_res_all, n_res_all;
    logic r_o_valid, n_o_valid, r_o_any, n_o_any, r_o_all, n_o_all;

    // Strobes from the output decoder.
    logic s_accept;
    logic issue;
    logic out_load;
    logic tbl_we;

    // Table RAM: {byte_size, start_address} per entry.
    logic [ircc_pkg::ENTRY_W-1:0] ram_q;
    logic [AW-1:0] rd_base, rd_size;

    ircc_ram #(
        .WIDTH (ircc_pkg::ENTRY_W),
        .DEPTH (ircc_pkg::MAX_RANGES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (in_idx),
        .i_wdata ({in_size, in_addr}),
        .i_re    (issue),
        .i_raddr (r_iss[IW-1:0]),
        .o_rdata (ram_q)
    );

    // An entry never written since reset reads as base 0, length 0.
    assign rd_base = r_p1_ok ? ram_q[AW-1:0]    : '0;
    assign rd_size = r_p1_ok ? ram_q[2*AW-1:AW] : '0;

    // Stage two: overlap test and furthest reach from the cursor.
    logic hit, cov, pass_end;
    logic [AW-1:0] pass_best;

    assign hit = r_p2_v && r_p2_live && r_p2_use
                 && (r_p2_base < r_wend) && (r_p2_end > r_addr);
    assign cov = r_p2_v && r_p2_live && r_p2_use
                 && (r_p2_base <= r_cursor) && (r_p2_end > r_best);
    assign pass_end  = (r_state == ircc_pkg::S_SCAN) && r_p2_v
                       && (!r_p2_live || r_p2_last);
    assign pass_best = cov ? r_p2_end : r_best;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ircc_pkg::S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    if (in_cmd == ircc_pkg::CMD_QUERY && in_size != '0 && !win_sum[AW]) begin
                        n_state = ircc_pkg::S_SCAN;
                    end else begin
                        n_state = ircc_pkg::S_RESULT;
                    end
                end
            end
            ircc_pkg::S_SCAN: begin
                if (pass_end) begin
                    n_state = ircc_pkg::S_EVAL;
                end
            end
            ircc_pkg::S_EVAL: begin
                if (r_best == r_cursor || r_best >= r_wend) begin
                    n_state = ircc_pkg::S_RESULT;
                end else begin
                    n_state = ircc_pkg::S_SCAN;
                end
            end
            ircc_pkg::S_RESULT: begin
                if (!r_o_valid || i_m_axis_tready) begin
                    n_state = ircc_pkg::S_IDLE;
                end
            end
            default: n_state = ircc_pkg::S_IDLE;
        endcase
    end

    // Output decoder.
    always_comb begin
        o_s_axis_tready = 1'b0;
        issue           = 1'b0;
        out_load        = 1'b0;
        unique case (r_state)
            ircc_pkg::S_IDLE:   o_s_axis_tready = 1'b1;
            ircc_pkg::S_SCAN:   issue = (r_iss < ircc_pkg::CNT_W'(ircc_pkg::MAX_RANGES))
                                        && !pass_end;
            ircc_pkg::S_EVAL:   issue = 1'b0;
            ircc_pkg::S_RESULT: out_load = !r_o_valid || i_m_axis_tready;
            default:            issue = 1'b0;
        endcase
    end

    assign s_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign tbl_we   = s_accept && (in_cmd == ircc_pkg::CMD_WRITE);

    // Datapath next values.
    always_comb begin
        n_valid   = r_valid;
        n_iss     = r_iss;
        n_addr    = r_addr;
        n_wend    = r_wend;
        n_cursor  = r_cursor;
        n_best    = r_best;
        n_any     = r_any;
        n_res_any = r_res_any;
        n_res_all = r_res_all;

        // Read pipeline: RAM output, then base, end and flags.
        n_p1_v    = issue;
        n_p1_last = (r_iss == ircc_pkg::CNT_W'(ircc_pkg::MAX_RANGES - 1));
        n_p1_ok   = r_valid[r_iss[IW-1:0]];
        n_p2_v    = r_p1_v && !pass_end;
        n_p2_last = r_p1_last;
        n_p2_live = (rd_size != '0);
        n_p2_use  = !rd_base[AW-1] && !rd_size[AW-1];
        n_p2_base = rd_base;
        n_p2_end  = rd_base + rd_size;

        if (tbl_we) begin
            n_valid[in_idx] = 1'b1;
        end

        if (s_accept) begin
            n_addr    = in_addr;
            n_wend    = win_sum[AW-1:0];
            n_cursor  = in_addr;
            n_best    = in_addr;
            n_any     = 1'b0;
            n_iss     = '0;
            // Writes answer 0, 0; a malformed window answers 1, 0.
            n_res_any = (in_cmd == ircc_pkg::CMD_QUERY);
            n_res_all = 1'b0;
        end

        if (issue) begin
            n_iss = r_iss + 1'b1;
        end

        if (hit) begin
            n_any = 1'b1;
        end
        if (cov) begin
            n_best = r_p2_end;
        end

        if (pass_end) begin
            n_p1_v = 1'b0;
            n_iss  = '0;
            n_best = pass_best;
        end

        if (r_state == ircc_pkg::S_EVAL) begin
            n_res_any = r_any;
            if (r_best == r_cursor) begin
                n_res_all = 1'b0;
            end else if (r_best >= r_wend) begin
                n_res_all = 1'b1;
            end else begin
                n_cursor = r_best;
            end
        end

        // Output register.
        n_o_valid = r_o_valid && !i_m_axis_tready;
        n_o_any   = r_o_any;
        n_o_all   = r_o_all;
        if (out_load) begin
            n_o_valid = 1'b1;
            n_o_any   = r_res_any;
            n_o_all   = r_res_all;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ircc_pkg::S_IDLE;
            r_valid   <= '0;
            r_iss     <= '0;
            r_p1_v    <= 1'b0;
            r_p2_v    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_valid   <= n_valid;
            r_iss     <= n_iss;
            r_p1_v    <= n_p1_v;
            r_p2_v    <= n_p2_v;
            r_o_valid <= n_o_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_p1_last <= n_p1_last;
        r_p1_ok   <= n_p1_ok;
        r_p2_last <= n_p2_last;
        r_p2_live <= n_p2_live;
        r_p2_use  <= n_p2_use;
        r_p2_base <= n_p2_base;
        r_p2_end  <= n_p2_end;
        r_addr    <= n_addr;
        r_wend    <= n_wend;
        r_cursor  <= n_cursor;
        r_best    <= n_best;
        r_any     <= n_any;
        r_res_any <= n_res_any;
        r_res_all <= n_res_all;
        r_o_any   <= n_o_any;
        r_o_all   <= n_o_all;
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {{(ircc_pkg::OUT_TDATA_W - 2){1'b0}}, r_o_all, r_o_any};

endmodule

`default_nettype wire

// ----- hw/rtl/ircc_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module ircc_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                  i_wdata,
    input  wire logic                              i_re,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output      logic [WIDTH-1:0]                  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire
